/* design/ps2_sed_pkg.sv */
// Shared codes and types for the PS/2 set-2 scancode event decoder.
package ps2_sed_pkg;

  // Prefix and key codes from scancode set 2.
  localparam logic [7:0] CodeRelease  = 8'hF0;
  localparam logic [7:0] CodeExtended = 8'hE0;
  localparam logic [7:0] CodeLShift   = 8'h12;
  localparam logic [7:0] CodeRShift   = 8'h59;
  localparam logic [7:0] CodeAlt      = 8'h11;
  localparam logic [7:0] CodeCtrl     = 8'h14;
  localparam logic [7:0] CodeCaps     = 8'h58;

  // Bit positions in the modifier word.
  localparam int unsigned ModShiftBit = 0;
  localparam int unsigned ModAltBit   = 1;
  localparam int unsigned ModCtrlBit  = 2;
  localparam int unsigned ModCapsBit  = 3;

  // Prefix tracker, one-hot.
  typedef enum logic [2:0] {
    PFX_IDLE     = 3'b001,
    PFX_RELEASE  = 3'b010,
    PFX_EXTENDED = 3'b100
  } prefix_e;

  typedef logic [3:0] mods_t;

endpackage

/* design/ps2_scancode_event_decoder_core.sv */
// Top level: PS/2 set-2 scancode decoder with prefix tracking and modifier state.
// Each accepted word is held in the input register, then its result in the result register.
// Throughput: one scancode word per cycle while the result is not stalled; the decode is a single short pass.
// Prefix and modifier-only words produce no output word.
// Reset (rst_ni low, asynchronous) clears both stage valids, the prefix state,
// the modifier bits and the caps lock held latch.
module ps2_scancode_event_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] key_code_o,
  output logic       is_release_o,
  output logic [3:0] modifier_bits_o
);
  import ps2_sed_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;

  prefix_e    pfx_q, pfx_d;
  mods_t      mods_q, mods_d;
  logic       caps_held_q, caps_held_d;

  logic       out_valid_q;
  logic [7:0] key_code_q;
  logic       is_release_q;
  mods_t      mods_out_q;

  logic       advance;
  logic       is_key;
  logic       release_w;
  logic       emit_w;

  // The held word moves on when the result slot is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= scan_byte_i;
    end
  end

  // Prefix tracking: decide whether this word completes a key sequence.
  always_comb begin
    pfx_d     = pfx_q;
    is_key    = 1'b0;
    release_w = 1'b0;
    case (pfx_q)
      PFX_RELEASE: begin
        // Whatever follows the release prefix is the key code.
        release_w = 1'b1;
        is_key    = 1'b1;
      end
      PFX_EXTENDED: begin
        if (byte_q == CodeRelease) begin
          pfx_d = PFX_RELEASE;
        end else begin
          is_key = 1'b1;
        end
      end
      default: begin
        if (byte_q == CodeRelease) begin
          pfx_d = PFX_RELEASE;
        end else if (byte_q == CodeExtended) begin
          pfx_d = PFX_EXTENDED;
        end else begin
          is_key = 1'b1;
        end
      end
    endcase
    if (is_key) begin
      pfx_d = PFX_IDLE;
    end
  end

  // Modifier handling for a completed key; other keys give an event.
  always_comb begin
    mods_d      = mods_q;
    caps_held_d = caps_held_q;
    emit_w      = 1'b0;
    if (is_key) begin
      case (byte_q)
        CodeLShift, CodeRShift: mods_d[ModShiftBit] = !release_w;
        CodeAlt:                mods_d[ModAltBit]   = !release_w;
        CodeCtrl:               mods_d[ModCtrlBit]  = !release_w;
        CodeCaps: begin
          // Caps lock toggles once per press; the release only frees the latch.
          if (release_w) begin
            caps_held_d = 1'b0;
          end else if (!caps_held_q) begin
            mods_d[ModCapsBit] = !mods_q[ModCapsBit];
            caps_held_d        = 1'b1;
          end
        end
        default: emit_w = 1'b1;
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfx_q       <= PFX_IDLE;
      mods_q      <= '0;
      caps_held_q <= 1'b0;
    end else if (advance) begin
      pfx_q       <= pfx_d;
      mods_q      <= mods_d;
      caps_held_q <= caps_held_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit_w;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_w) begin
      key_code_q   <= byte_q;
      is_release_q <= release_w;
      mods_out_q   <= mods_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_code_o      = key_code_q;
  assign is_release_o    = is_release_q;
  assign modifier_bits_o = mods_out_q;

endmodule

/* design/ps2_sed_checker.sv */
// Port-level checks for the scancode decoder, bound to its top level.
module ps2_sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] key_code_o,
  input logic       is_release_o,
  input logic [3:0] modifier_bits_o
);
  import ps2_sed_pkg::*;

  // Modifier keys never show up as events.
  a_no_modifier_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_code_o != CodeLShift && key_code_o != CodeRShift &&
                     key_code_o != CodeAlt && key_code_o != CodeCtrl &&
                     key_code_o != CodeCaps))
    else $error("modifier key reported as an event");

  // A release prefix cannot be reported as a pressed key.
  a_no_f0_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_release_o) |-> (key_code_o != CodeRelease))
    else $error("release prefix reported as a press");

  // The input side stalls only while a result word is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result word");

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(key_code_o) && $stable(is_release_o) &&
       $stable(modifier_bits_o)))
    else $error("stalled result word changed");

endmodule

bind ps2_scancode_event_decoder_core ps2_sed_checker u_ps2_sed_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .key_code_o     (key_code_o),
  .is_release_o   (is_release_o),
  .modifier_bits_o(modifier_bits_o)
);

/* sim/testbench.sv */
// Self-checking testbench for the PS/2 set-2 scancode event decoder core.
module testbench;
  import ps2_sed_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned IdlePct      = 34;
  localparam int unsigned TotalWords   = 1300;

  // One key event as the decoder reports it.
  typedef struct packed {
    logic [7:0] key_code;
    logic       is_release;
    mods_t      mods;
  } scan_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] scan_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] key_code_o;
  logic       is_release_o;
  logic [3:0] modifier_bits_o;

  // Decoder state as the testbench tracks it.
  prefix_e      prefix_q;
  mods_t        mods_q;
  logic         caps_held_q;
  scan_result_t pending_events[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned words_sent;
  int unsigned err_count;
  int unsigned cycle_count;

  ps2_scancode_event_decoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .scan_byte_i    (scan_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_code_o     (key_code_o),
    .is_release_o   (is_release_o),
    .modifier_bits_o(modifier_bits_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one completed key to the modifier state; returns 1 for a reportable key.
  function automatic logic apply_key(input logic [7:0] code, input logic rel);
    if (code == CodeLShift || code == CodeRShift) begin
      mods_q[ModShiftBit] = ~rel;
      return 1'b0;
    end
    if (code == CodeAlt) begin
      mods_q[ModAltBit] = ~rel;
      return 1'b0;
    end
    if (code == CodeCtrl) begin
      mods_q[ModCtrlBit] = ~rel;
      return 1'b0;
    end
    if (code == CodeCaps) begin
      if (rel) begin
        caps_held_q = 1'b0;
      end else if (!caps_held_q) begin
        mods_q[ModCapsBit] = ~mods_q[ModCapsBit];
        caps_held_q = 1'b1;
      end
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the prefix tracker by one scancode word and queue any key event.
  function automatic void decode_scan(input logic [7:0] scan);
    logic         rel;
    scan_result_t ev;
    rel = 1'b0;
    case (prefix_q)
      PFX_RELEASE: begin
        rel = 1'b1;
      end
      PFX_EXTENDED: begin
        if (scan == CodeRelease) begin
          prefix_q = PFX_RELEASE;
          return;
        end
      end
      default: begin
        if (scan == CodeRelease) begin
          prefix_q = PFX_RELEASE;
          return;
        end
        if (scan == CodeExtended) begin
          prefix_q = PFX_EXTENDED;
          return;
        end
      end
    endcase
    prefix_q = PFX_IDLE;
    if (apply_key(scan, rel)) begin
      ev.key_code   = scan;
      ev.is_release = rel;
      ev.mods       = mods_q;
      pending_events.push_back(ev);
    end
  endfunction

  // Offer one word, with a random gap first, and predict once it is taken.
  task automatic send_scan(input logic [7:0] scan);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_byte_i <= scan;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    decode_scan(scan);
    words_sent++;
  endtask

  // Hold off the sender until every predicted event has come out.
  task automatic pause_for_results();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Pick a key, biased toward the modifier keys.
  function automatic logic [7:0] pick_key();
    case ($urandom_range(9))
      0: return ($urandom_range(1) != 0) ? CodeLShift : CodeRShift;
      1: return ($urandom_range(1) != 0) ? CodeAlt : CodeCtrl;
      2: return CodeCaps;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One scancode sequence: press, release, extended press or release, or a stray word.
  task automatic send_key_sequence();
    int unsigned kind;
    logic [7:0]  code;
    kind = $urandom_range(99);
    code = pick_key();
    if (kind < 45) begin
      send_scan(code);
    end else if (kind < 75) begin
      send_scan(CodeRelease);
      send_scan(code);
    end else if (kind < 85) begin
      send_scan(CodeExtended);
      send_scan(code);
    end else if (kind < 95) begin
      send_scan(CodeExtended);
      send_scan(CodeRelease);
      send_scan(code);
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  // Field extremes, every modifier, caps lock latching and odd prefix pairs.
  task automatic test_directed();
    logic [7:0] words[$];
    words = '{8'h00, 8'hFF, CodeLShift, CodeAlt, CodeCtrl, CodeCaps, CodeCaps, 8'h1C,
              CodeRelease, CodeCaps, CodeRelease, CodeLShift,
              CodeExtended, CodeRelease, CodeAlt,
              CodeRelease, CodeRelease, CodeRelease, CodeExtended,
              CodeExtended, CodeExtended,
              CodeExtended, CodeRelease, CodeCtrl, CodeCaps, 8'h7E};
    foreach (words[i]) send_scan(words[i]);
    pause_for_results();
  endtask

  // Random sequences with both sides idling at random.
  task automatic test_random_idling(input int unsigned upto);
    gap_pct   = IdlePct;
    stall_pct = IdlePct;
    while (words_sent < upto) send_key_sequence();
    pause_for_results();
  endtask

  // Random sequences at full rate with no stalls at all.
  task automatic test_random_back_to_back(input int unsigned upto);
    gap_pct   = 0;
    stall_pct = 0;
    while (words_sent < upto) send_key_sequence();
    pause_for_results();
  endtask

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each taken result with the oldest predicted event.
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word key_code=%h is_release=%b modifier_bits=%h",
                 $time, key_code_o, is_release_o, modifier_bits_o);
      end else begin
        want = pending_events.pop_front();
        if (key_code_o !== want.key_code) begin
          err_count++;
          $display("%0t: key_code expected %h actual %h", $time, want.key_code, key_code_o);
        end
        if (is_release_o !== want.is_release) begin
          err_count++;
          $display("%0t: is_release expected %b actual %b",
                   $time, want.is_release, is_release_o);
        end
        if (modifier_bits_o !== want.mods) begin
          err_count++;
          $display("%0t: modifier_bits expected %h actual %h",
                   $time, want.mods, modifier_bits_o);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    scan_byte_i = 8'h00;
    out_stall_i = 1'b0;
    gap_pct     = IdlePct;
    stall_pct   = IdlePct;
    words_sent  = 0;
    err_count   = 0;
    cycle_count = 0;
    prefix_q    = PFX_IDLE;
    mods_q      = '0;
    caps_held_q = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_idling(600);
    test_random_back_to_back(950);
    test_random_idling(TotalWords);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
